/* rtl/lts_pkg.sv */
// ----------------------------------------------------------------------------
// lts_pkg
// Shared constants and types for the increasing-run length tracker.
// ----------------------------------------------------------------------------
package lts_pkg;

  // Capacity of the tails store, one cell per entry.
  localparam int MAX_LEN     = 256;
  // Width of one stored value.
  localparam int VALUE_WIDTH = 32;

  // Width of the value field on the input stream.
  localparam int IN_VALUE_W  = 32;
  // Input bits that carry the value before sign extension.
  localparam int SRC_W       = (VALUE_WIDTH < IN_VALUE_W) ? VALUE_WIDTH : IN_VALUE_W;

  // Internal length counter holds 0..MAX_LEN.
  localparam int LEN_W       = $clog2(MAX_LEN + 1);
  // Length field on the output stream.
  localparam int OUT_LEN_W   = 9;

  // Stream data widths, padded to whole bytes.
  localparam int S_DATA_W    = ((IN_VALUE_W + 7) / 8) * 8;
  localparam int M_DATA_W    = ((OUT_LEN_W + 1 + 7) / 8) * 8;

  // Per-beat control broadcast to every cell.
  typedef struct packed {
    logic en;     // input beat accepted this cycle
    logic clear;  // beat ends the sequence: drop all occupancy
  } cell_ctl_t;

endpackage

/* rtl/lts_cell.sv */
// ----------------------------------------------------------------------------
// lts_cell
// One entry of the tails store: holds a value and an occupied flag, compares
// the broadcast value and takes it when it is the first entry not smaller.
// ----------------------------------------------------------------------------
module lts_cell (
  input  logic                                   clk,
  input  logic                                   rst,
  input  lts_pkg::cell_ctl_t                     ctl,
  input  logic signed [lts_pkg::VALUE_WIDTH-1:0] value,
  input  logic                                   left_less,  // all cells to the left hold smaller
  output logic                                   less,       // this cell holds a smaller value
  output logic                                   appended    // value would land in an empty cell
);

  logic signed [lts_pkg::VALUE_WIDTH-1:0] tail;
  logic                                   occ;
  logic                                   take;

  assign less     = occ && (tail < value);
  // tails are strictly increasing, so less is a prefix over the row
  assign take     = left_less && !less;
  assign appended = left_less && !occ;

  always_ff @(posedge clk) begin
    if (ctl.en && take) begin
      tail <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctl.en) begin
      if (ctl.clear) begin
        occ <= 1'b0;
      end else if (take) begin
        occ <= 1'b1;
      end
    end
  end

endmodule

/* rtl/lis_length_tails_stream.sv */
// ----------------------------------------------------------------------------
// lis_length_tails_stream
// Length of the longest strictly increasing subsequence of a value stream.
// ----------------------------------------------------------------------------
// Input beats carry one signed value each (s_tdata) and s_tlast on the final
// value of a sequence. Every input beat yields one output beat with the
// running length, the sticky overflow mark and an echo of tlast.
// A row of MAX_LEN cells holds the tails; each cell compares the incoming
// value against its entry and passes its "smaller" flag to its right
// neighbor, so the first cell not smaller takes the value in the same cycle.
// Each output beat is registered and shows in the cycle after its input beat;
// one beat per cycle is sustained while m_tready stays high; the single
// compare per cell plus the neighbor flag set that rate.
// The output register frees up in the cycle it is taken, so s_tready stays
// high while the receiver keeps m_tready high; a stalled output holds its
// beat and input is held off until it is taken.
// Reset clears length, overflow and all occupancy; no sweep is needed.
// After a tlast beat the length and overflow mark restart at zero.
// ----------------------------------------------------------------------------
module lis_length_tails_stream (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [lts_pkg::S_DATA_W-1:0]  s_tdata,   // [31:0] value
  input  logic                          s_tlast,   // last
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [lts_pkg::M_DATA_W-1:0]  m_tdata,   // [8:0] lis_length, [9] overflow
  output logic                          m_tlast    // last_out
);

  localparam int N = lts_pkg::MAX_LEN;

  logic signed [lts_pkg::VALUE_WIDTH-1:0] value;
  logic                                   accept;
  lts_pkg::cell_ctl_t                     ctl;
  logic [N-1:0]                           less;
  logic [N-1:0]                           appended;
  logic [N-1:0]                           left_less;
  logic                                   grow;

  logic [lts_pkg::LEN_W-1:0]              length;
  logic [lts_pkg::LEN_W-1:0]              length_next;
  logic                                   ovf_seen;
  logic                                   ovf_next;

  logic [lts_pkg::OUT_LEN_W-1:0]          out_len;
  logic                                   out_ovf;

  assign value     = lts_pkg::VALUE_WIDTH'($signed(s_tdata[lts_pkg::SRC_W-1:0]));
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign ctl       = '{en: accept, clear: s_tlast};

  assign left_less = {less[N-2:0], 1'b1};

  genvar gi;
  generate
    for (gi = 0; gi < N; gi++) begin : g_cell
      lts_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl),
        .value     (value),
        .left_less (left_less[gi]),
        .less      (less[gi]),
        .appended  (appended[gi])
      );
    end
  endgenerate

  // the last cell being smaller means the row is full and the append drops
  assign grow        = |appended;
  assign length_next = grow ? length + lts_pkg::LEN_W'(1) : length;
  assign ovf_next    = ovf_seen || less[N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      length   <= '0;
      ovf_seen <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        length   <= s_tlast ? '0 : length_next;
        ovf_seen <= s_tlast ? 1'b0 : ovf_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_len <= lts_pkg::OUT_LEN_W'(32'(length_next));
      out_ovf <= ovf_next;
      m_tlast <= s_tlast;
    end
  end

  assign m_tdata = lts_pkg::M_DATA_W'({out_ovf, out_len});

  // ---------------------------------------------------------------- checks
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    length <= lts_pkg::LEN_W'(N))
    else $error("length beyond capacity");

  a_one_append: assert property (@(posedge clk) disable iff (rst)
    $onehot0(appended))
    else $error("more than one cell appends");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    less[N-1] |-> (length == lts_pkg::LEN_W'(N)))
    else $error("drop flagged on a store that is not full");

  a_last_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=> (length == '0) && !ovf_seen)
    else $error("sequence end did not clear state");

  a_grow_room: assert property (@(posedge clk) disable iff (rst)
    grow |-> (length != lts_pkg::LEN_W'(N)))
    else $error("append into a full store");

endmodule

/* verif/lis_length_tails_stream_tb.sv */
// ----------------------------------------------------------------------------
// lis_length_tails_stream_tb
// Self-checking bench for the streaming longest-increasing-run length tracker.
// ----------------------------------------------------------------------------
// A local tails model computes the length, overflow mark and tlast echo for
// every accepted input beat. Output beats are compared in order against those
// predictions. Stimulus covers value extremes, equal and falling values, a
// full store with dropped appends, and random sequences. Both sides idle at
// random, with stretches at full rate.
// ----------------------------------------------------------------------------
module lis_length_tails_stream_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic [lts_pkg::OUT_LEN_W-1:0] run_len;
    logic                          ovf;
    logic                          fin;
  } lis_beat_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_tvalid;
  logic                         s_tready;
  logic [lts_pkg::S_DATA_W-1:0] s_tdata;   // [31:0] value
  logic                         s_tlast;   // last
  logic                         m_tvalid;
  logic                         m_tready;
  logic [lts_pkg::M_DATA_W-1:0] m_tdata;   // [8:0] lis_length, [9] overflow
  logic                         m_tlast;   // last_out

  // tails model
  logic signed [31:0] tails_mdl [lts_pkg::MAX_LEN];
  int                 len_mdl;
  logic               ovf_mdl;

  lis_beat_t expected_lengths [$];
  int        mismatches;
  int        beats_sent;
  bit        full_rate;

  lis_length_tails_stream dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) begin
      $display("%0t mismatch: %s", $realtime, msg);
    end
  endtask

  function automatic int draw_gap();
    if (full_rate) begin
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  // One step of the tails method; state clears after a tlast beat.
  function automatic lis_beat_t advance_tails(input logic signed [31:0] v, input logic fin);
    lis_beat_t b;
    int        pos;
    if (len_mdl == 0 || v > tails_mdl[len_mdl-1]) begin
      if (len_mdl < lts_pkg::MAX_LEN) begin
        tails_mdl[len_mdl] = v;
        len_mdl++;
      end else begin
        ovf_mdl = 1'b1;
      end
    end else begin
      pos = 0;
      while (tails_mdl[pos] < v) pos++;
      tails_mdl[pos] = v;
    end
    b.run_len = len_mdl[lts_pkg::OUT_LEN_W-1:0];
    b.ovf     = ovf_mdl;
    b.fin     = fin;
    if (fin) begin
      len_mdl = 0;
      ovf_mdl = 1'b0;
    end
    return b;
  endfunction

  task automatic send_value(input logic signed [31:0] v, input logic fin);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= fin;
    expected_lengths.push_back(advance_tails(v, fin));
    beats_sent++;
    do @(posedge clk); while (!s_tready);
  endtask

  // Output side: random stall before each beat.
  initial begin
    int gap;
    m_tready <= 1'b0;
    wait (!rst);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin
    lis_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_lengths.size() == 0) begin
        report_mismatch($sformatf("unexpected beat len=%0d",
                                  m_tdata[lts_pkg::OUT_LEN_W-1:0]));
      end else begin
        want = expected_lengths.pop_front();
        if (m_tdata[lts_pkg::OUT_LEN_W-1:0] !== want.run_len)
          report_mismatch($sformatf("lis_length %0d, want %0d",
                                    m_tdata[lts_pkg::OUT_LEN_W-1:0], want.run_len));
        if (m_tdata[lts_pkg::OUT_LEN_W] !== want.ovf)
          report_mismatch($sformatf("overflow %b, want %b",
                                    m_tdata[lts_pkg::OUT_LEN_W], want.ovf));
        if (m_tlast !== want.fin)
          report_mismatch($sformatf("last_out %b, want %b", m_tlast, want.fin));
      end
    end
  end

  // Extremes, equal values, falling runs, single-beat sequences.
  task automatic test_edge_values();
    full_rate = 1'b0;
    send_value(VAL_MIN, 1'b1);                // empty store takes the minimum
    send_value(VAL_MAX, 1'b0);
    send_value(VAL_MIN, 1'b0);
    send_value(32'sd0, 1'b0);
    send_value(-32'sd1, 1'b0);
    send_value(32'sd0, 1'b0);                 // rises above -1 and appends
    send_value(32'sd1, 1'b0);
    send_value(VAL_MAX, 1'b0);
    send_value(VAL_MAX, 1'b1);
    send_value(32'sd5, 1'b0);
    send_value(32'sd4, 1'b0);
    send_value(32'sd3, 1'b0);
    send_value(32'sd2, 1'b1);
    send_value(32'sd7, 1'b0);
    send_value(32'sd7, 1'b0);
    send_value(32'sd7, 1'b1);
    send_value(VAL_MAX, 1'b1);
    send_value(32'sh5555_5555, 1'b0);
    send_value(32'shaaaa_aaaa, 1'b0);
    send_value(32'sh5555_5555, 1'b0);
    send_value(32'sh7fff_fffe, 1'b1);
  endtask

  // Fill every cell, push appends past the end, then replace while full.
  task automatic test_full_store(input bit at_full_rate);
    longint top;
    full_rate = at_full_rate;
    top = longint'(VAL_MIN) + $urandom_range(0, 1 << 20);
    for (int i = 0; i < lts_pkg::MAX_LEN; i++) begin
      send_value(32'(top), 1'b0);
      top += $urandom_range(1, 1 << 22);
    end
    send_value(32'(top), 1'b0);               // dropped append
    send_value(VAL_MAX, 1'b0);
    send_value(32'(top - 64'sd3), 1'b0);
    send_value(VAL_MIN, 1'b0);                // replacement while full
    send_value(VAL_MAX, 1'b0);
    send_value($urandom, 1'b1);
  endtask

  task automatic test_random_sequences(input int n_items);
    int             seq_len;
    int             mode;
    int             stop_at;
    longint         prev;
    logic signed [31:0] v;
    stop_at = beats_sent + n_items;
    while (beats_sent < stop_at) begin
      full_rate = ($urandom_range(0, 4) == 0);
      seq_len   = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 160)
                                              : $urandom_range(1, 40);
      mode      = $urandom_range(0, 4);
      prev      = longint'($signed($urandom)) >>> 2;
      for (int i = 0; i < seq_len; i++) begin
        case (mode)
          0: v = $urandom;
          1: v = $signed($urandom_range(0, 8)) - 32'sd4;
          2: begin
            case ($urandom_range(0, 4))
              0: v = VAL_MIN;
              1: v = VAL_MAX;
              2: v = -32'sd1;
              3: v = 32'sd0;
              default: v = 32'sd1;
            endcase
          end
          default: begin
            // mostly rising with some drops
            prev += longint'($urandom_range(0, 300)) - 60;
            v = 32'(prev);
          end
        endcase
        send_value(v, i == seq_len - 1);
      end
    end
  endtask

  initial begin
    s_tvalid   <= 1'b0;
    s_tdata    <= '0;
    s_tlast    <= 1'b0;
    len_mdl    = 0;
    ovf_mdl    = 1'b0;
    mismatches = 0;
    beats_sent = 0;
    full_rate  = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_edge_values();
    test_full_store(1'b1);
    test_random_sequences(350);
    test_full_store(1'b0);
    test_random_sequences(400);

    s_tvalid <= 1'b0;
    while (expected_lengths.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
